FILE: hw/rtl/wavp_pkg.sv
// shared types and constants for the wav pcm16 stream parser
// no dependencies; imported by the parser top level
package wavp_pkg;

	// file length limits
	localparam int unsigned MAX_FILE_BYTES_DEF = 536870912;
	localparam logic [29:0] MIN_FILE_BYTES     = 30'd44;

	// accepted sample rate range in hertz
	localparam logic [31:0] RATE_MIN = 32'd8000;
	localparam logic [31:0] RATE_MAX = 32'd192000;

	// four character tags, first file byte in the top byte
	localparam logic [31:0] TAG_RIFF = 32'h52494646;
	localparam logic [31:0] TAG_WAVE = 32'h57415645;
	localparam logic [31:0] TAG_FMT  = 32'h666D7420;
	localparam logic [31:0] TAG_DATA = 32'h64617461;

	// first chunk header follows the riff header
	localparam logic [30:0] FIRST_CHUNK = 31'd12;

	// wave format code for integer pcm
	localparam logic [15:0] FMT_PCM  = 16'd1;
	localparam logic [15:0] BITS_16  = 16'd16;

	typedef enum logic [1:0] {
		KIND_HEADER = 2'd0,
		KIND_SAMPLE = 2'd1,
		KIND_ERROR  = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ERR_BAD_LENGTH = 3'd0,
		ERR_NOT_WAVE   = 3'd1,
		ERR_CHUNK_LONG = 3'd2,
		ERR_NO_DATA    = 3'd3,
		ERR_BAD_FORMAT = 3'd4
	} err_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_of_file;
	} in_word_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [15:0] sample;
		logic               channel;
		logic [1:0]         num_channels;
		logic [17:0]        sample_rate;
		logic [29:0]        data_bytes;
		err_t               error_code;
		logic               last;
	} out_word_t;

	// byte idx (0 first) of a four character tag
	function automatic logic [7:0] tag_byte(input logic [31:0] tag, input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0:    r = tag[31:24];
			2'd1:    r = tag[23:16];
			2'd2:    r = tag[15:8];
			default: r = tag[7:0];
		endcase
		return r;
	endfunction

endpackage

FILE: hw/rtl/wav_pcm16_stream_parser_top.sv
// riff/wave pcm16 stream parser: byte stream in, header/sample/error words out
// depends on wavp_pkg for word types, tags and limits
//
// Takes one file byte per clock and produces at most one result word per byte, so the
// sustained rate, while the result side does not stall, is one byte every cycle with no
// gaps between files. A byte goes through an input register, then one pass of parse logic
// writes the parser state and the result register. Stall on the result side holds the
// input register and then stalls the byte side. Load file_length before the first byte of
// a file; start_of_file restarts parsing at any byte, and after an error or the last
// sample bytes are dropped until the next start_of_file.
module wav_pcm16_stream_parser_top #(
	parameter int unsigned MAX_FILE_BYTES = wavp_pkg::MAX_FILE_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [29:0]         cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  wavp_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output wavp_pkg::out_word_t out_data
);
	import wavp_pkg::*;

	localparam logic [29:0] MaxLen = 30'(MAX_FILE_BYTES);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_RIFF,
		PH_CHDR,
		PH_BODY,
		PH_PAD,
		PH_DATA
	} phase_t;

	// input stage
	logic     s1_valid;
	in_word_t word_s1;

	// result register
	logic      out_valid_q;
	out_word_t out_word_q;

	// parser state
	logic [29:0] file_length_q;
	phase_t      phase_q, phase_d;
	logic [29:0] pos_q, pos_d;
	logic [2:0]  hdr_cnt_q, hdr_cnt_d;
	logic [4:0]  body_cnt_q, body_cnt_d;
	logic [31:0] body_start_q, body_start_d;
	logic [30:0] body_end_q, body_end_d;
	logic [31:0] chunk_tag_q, chunk_tag_d;
	logic [31:0] chunk_size_q, chunk_size_d;
	logic [15:0] fmt_code_q, fmt_code_d;
	logic [15:0] chan_cnt_q, chan_cnt_d;
	logic [15:0] bits_q, bits_d;
	logic [31:0] rate_q, rate_d;
	logic [29:0] remaining_q, remaining_d;
	logic [7:0]  low_hold_q, low_hold_d;
	logic        toggle_q, toggle_d;

	logic      produce;
	out_word_t res;
	logic      out_free, advance;

	// scratch values for the parse pass
	logic [29:0] cur_pos;
	logic [7:0]  b;
	logic [32:0] chunk_end;
	logic [30:0] next_chunk;
	logic [31:0] next_body;
	logic        fmt_ok;

	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = s1_valid && out_free;
	assign in_stall  = s1_valid && !out_free;
	assign out_valid = out_valid_q;
	assign out_data  = out_word_q;

	// one parse step for the registered byte
	always_comb begin
		phase_d      = phase_q;
		pos_d        = pos_q;
		hdr_cnt_d    = hdr_cnt_q;
		body_cnt_d   = body_cnt_q;
		body_start_d = body_start_q;
		body_end_d   = body_end_q;
		chunk_tag_d  = chunk_tag_q;
		chunk_size_d = chunk_size_q;
		fmt_code_d   = fmt_code_q;
		chan_cnt_d   = chan_cnt_q;
		bits_d       = bits_q;
		rate_d       = rate_q;
		remaining_d  = remaining_q;
		low_hold_d   = low_hold_q;
		toggle_d     = toggle_q;
		produce      = 1'b0;
		res          = '0;
		b            = word_s1.data_byte;
		chunk_end    = '0;
		next_chunk   = '0;
		next_body    = '0;
		fmt_ok       = 1'b0;

		// start of file resets all parser state to its start values; the length register is kept
		if (word_s1.start_of_file) begin
			phase_d      = PH_RIFF;
			pos_d        = '0;
			hdr_cnt_d    = '0;
			body_cnt_d   = '0;
			body_start_d = {1'b0, FIRST_CHUNK} + 32'd8;
			body_end_d   = '0;
			chunk_tag_d  = '0;
			chunk_size_d = '0;
			fmt_code_d   = '0;
			chan_cnt_d   = '0;
			bits_d       = '0;
			rate_d       = '0;
			remaining_d  = '0;
			low_hold_d   = '0;
			toggle_d     = 1'b0;
		end

		cur_pos = pos_d;
		if (phase_d != PH_IDLE) begin
			pos_d = cur_pos + 30'd1;
		end

		case (phase_d)
			PH_RIFF: begin
				if (cur_pos == '0 && (file_length_q < MIN_FILE_BYTES || file_length_q > MaxLen)) begin
					produce        = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_BAD_LENGTH;
					res.last       = 1'b1;
					phase_d        = PH_IDLE;
				end else if (cur_pos < 30'd4 && b != tag_byte(TAG_RIFF, cur_pos[1:0])) begin
					produce        = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_NOT_WAVE;
					res.last       = 1'b1;
					phase_d        = PH_IDLE;
				end else if (cur_pos >= 30'd8 && cur_pos < 30'd12 &&
						b != tag_byte(TAG_WAVE, cur_pos[1:0])) begin
					produce        = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_NOT_WAVE;
					res.last       = 1'b1;
					phase_d        = PH_IDLE;
				end else if (cur_pos >= 30'd11) begin
					next_body = {1'b0, FIRST_CHUNK} + 32'd8;
					if (next_body > {2'b0, file_length_q}) begin
						produce        = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_NO_DATA;
						res.last       = 1'b1;
						phase_d        = PH_IDLE;
					end else begin
						body_start_d = next_body;
						phase_d      = PH_CHDR;
						hdr_cnt_d    = '0;
						chunk_tag_d  = '0;
						chunk_size_d = '0;
					end
				end
			end

			PH_CHDR: begin
				// tag big-end first, size little-endian
				if (!hdr_cnt_q[2]) begin
					chunk_tag_d = {chunk_tag_q[23:0], b};
				end else begin
					case (hdr_cnt_q[1:0])
						2'd0:    chunk_size_d[7:0]   = b;
						2'd1:    chunk_size_d[15:8]  = b;
						2'd2:    chunk_size_d[23:16] = b;
						default: chunk_size_d[31:24] = b;
					endcase
				end
				hdr_cnt_d = hdr_cnt_q + 3'd1;
				if (hdr_cnt_q == 3'd7) begin
					chunk_end = {1'b0, body_start_q} + {1'b0, chunk_size_d};
					fmt_ok = fmt_code_q == FMT_PCM && bits_q == BITS_16 &&
						rate_q >= RATE_MIN && rate_q <= RATE_MAX &&
						((chan_cnt_q == 16'd1 && !chunk_size_d[0]) ||
						 (chan_cnt_q == 16'd2 && chunk_size_d[1:0] == 2'd0));
					if (chunk_end > {3'b0, file_length_q}) begin
						produce        = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_CHUNK_LONG;
						res.last       = 1'b1;
						phase_d        = PH_IDLE;
					end else if (chunk_tag_d == TAG_DATA) begin
						produce = 1'b1;
						if (!fmt_ok) begin
							res.kind       = KIND_ERROR;
							res.error_code = ERR_BAD_FORMAT;
							res.last       = 1'b1;
							phase_d        = PH_IDLE;
						end else begin
							remaining_d      = chunk_size_d[29:0];
							toggle_d         = 1'b0;
							low_hold_d       = '0;
							phase_d          = (chunk_size_d == '0) ? PH_IDLE : PH_DATA;
							res.kind         = KIND_HEADER;
							res.num_channels = chan_cnt_q[1:0];
							res.sample_rate  = rate_q[17:0];
							res.data_bytes   = chunk_size_d[29:0];
							res.last         = (chunk_size_d == '0);
						end
					end else if (chunk_size_d == '0) begin
						// empty chunk: next header right after this one
						next_body = body_start_q + 32'd8;
						if (next_body > {2'b0, file_length_q}) begin
							produce        = 1'b1;
							res.kind       = KIND_ERROR;
							res.error_code = ERR_NO_DATA;
							res.last       = 1'b1;
							phase_d        = PH_IDLE;
						end else begin
							body_start_d = next_body;
							phase_d      = PH_CHDR;
							hdr_cnt_d    = '0;
							chunk_tag_d  = '0;
							chunk_size_d = '0;
						end
					end else begin
						// end fits within the file length here
						body_end_d = chunk_end[30:0];
						body_cnt_d = '0;
						phase_d    = PH_BODY;
					end
				end
			end

			PH_BODY: begin
				// latch fmt fields from the first sixteen body bytes
				if (chunk_tag_q == TAG_FMT && chunk_size_q >= 32'd16 && !body_cnt_q[4]) begin
					case (body_cnt_q[3:0])
						4'd0:    fmt_code_d[7:0]  = b;
						4'd1:    fmt_code_d[15:8] = b;
						4'd2:    chan_cnt_d[7:0]  = b;
						4'd3:    chan_cnt_d[15:8] = b;
						4'd4:    rate_d[7:0]      = b;
						4'd5:    rate_d[15:8]     = b;
						4'd6:    rate_d[23:16]    = b;
						4'd7:    rate_d[31:24]    = b;
						4'd14:   bits_d[7:0]      = b;
						4'd15:   bits_d[15:8]     = b;
						default: ;
					endcase
				end
				if (!body_cnt_q[4]) begin
					body_cnt_d = body_cnt_q + 5'd1;
				end
				if ({1'b0, cur_pos} + 31'd1 >= body_end_q) begin
					// odd sized chunks carry a pad byte
					next_chunk = body_end_q + {30'b0, chunk_size_q[0]};
					next_body  = {1'b0, next_chunk} + 32'd8;
					if (next_body > {2'b0, file_length_q}) begin
						produce        = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_NO_DATA;
						res.last       = 1'b1;
						phase_d        = PH_IDLE;
					end else begin
						body_start_d = next_body;
						if (chunk_size_q[0]) begin
							phase_d = PH_PAD;
						end else begin
							phase_d      = PH_CHDR;
							hdr_cnt_d    = '0;
							chunk_tag_d  = '0;
							chunk_size_d = '0;
						end
					end
				end
			end

			PH_PAD: begin
				phase_d      = PH_CHDR;
				hdr_cnt_d    = '0;
				chunk_tag_d  = '0;
				chunk_size_d = '0;
			end

			PH_DATA: begin
				remaining_d = remaining_q - 30'd1;
				if (remaining_d[0]) begin
					low_hold_d = b;
				end else begin
					produce     = 1'b1;
					res.kind    = KIND_SAMPLE;
					res.sample  = {b, low_hold_q};
					res.channel = toggle_q;
					res.last    = (remaining_d == '0);
					if (chan_cnt_q == 16'd2) begin
						toggle_d = !toggle_q;
					end
					if (remaining_d == '0) begin
						phase_d = PH_IDLE;
					end
				end
			end

			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// input register, result register and parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid      <= 1'b0;
			word_s1       <= '0;
			out_valid_q   <= 1'b0;
			out_word_q    <= '0;
			file_length_q <= '0;
			phase_q       <= PH_IDLE;
			pos_q         <= '0;
			hdr_cnt_q     <= '0;
			body_cnt_q    <= '0;
			body_start_q  <= {1'b0, FIRST_CHUNK} + 32'd8;
			body_end_q    <= '0;
			chunk_tag_q   <= '0;
			chunk_size_q  <= '0;
			fmt_code_q    <= '0;
			chan_cnt_q    <= '0;
			bits_q        <= '0;
			rate_q        <= '0;
			remaining_q   <= '0;
			low_hold_q    <= '0;
			toggle_q      <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				file_length_q <= cfg_wr_data;
			end
			if (in_valid && !in_stall) begin
				s1_valid <= 1'b1;
				word_s1  <= in_data;
			end else if (advance) begin
				s1_valid <= 1'b0;
			end
			if (out_free) begin
				out_valid_q <= advance && produce;
				out_word_q  <= res;
			end
			if (advance) begin
				phase_q      <= phase_d;
				pos_q        <= pos_d;
				hdr_cnt_q    <= hdr_cnt_d;
				body_cnt_q   <= body_cnt_d;
				body_start_q <= body_start_d;
				body_end_q   <= body_end_d;
				chunk_tag_q  <= chunk_tag_d;
				chunk_size_q <= chunk_size_d;
				fmt_code_q   <= fmt_code_d;
				chan_cnt_q   <= chan_cnt_d;
				bits_q       <= bits_d;
				rate_q       <= rate_d;
				remaining_q  <= remaining_d;
				low_hold_q   <= low_hold_d;
				toggle_q     <= toggle_d;
			end
		end
	end

	// an error word always closes the file
	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_word_q.kind == KIND_ERROR |-> out_word_q.last)
		else $error("error word without last");

	// a pending last word means the parser has gone idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_word_q.last |-> phase_q == PH_IDLE)
		else $error("last word while parser still active");

	// a header with samples to follow leaves the parser in the data body
	a_header_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_word_q.kind == KIND_HEADER && !out_word_q.last
		|-> phase_q == PH_DATA)
		else $error("header not followed by data phase");

	// the data phase never runs with an empty byte count
	a_data_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> remaining_q != '0)
		else $error("data phase with no bytes left");

endmodule
